>>> sv/qmr_pkg.sv
`timescale 1ns / 1ps

package qmr_pkg;

  localparam int unsigned DATA_WIDTH_DEF = 24;
  localparam int unsigned FRAC_BITS_DEF  = 16;

  // Three register stages per Hamilton pass: products, sums, shift and clip.
  localparam int unsigned PASS_LAT = 3;
  // Two passes plus the result register.
  localparam int unsigned LATENCY  = 2 * PASS_LAT + 1;

  typedef logic [1:0] idx_t;

  typedef struct packed {
    logic kind;
    logic sat;
  } qmr_ctl_t;

  // Hamilton product p*q, component k (x, y, z, w), term t.
  localparam idx_t P_IDX [4][4] = '{
    '{2'd3, 2'd0, 2'd1, 2'd2},
    '{2'd3, 2'd0, 2'd1, 2'd2},
    '{2'd3, 2'd0, 2'd1, 2'd2},
    '{2'd3, 2'd0, 2'd1, 2'd2}
  };

  localparam idx_t Q_IDX [4][4] = '{
    '{2'd0, 2'd3, 2'd2, 2'd1},
    '{2'd1, 2'd2, 2'd3, 2'd0},
    '{2'd2, 2'd1, 2'd0, 2'd3},
    '{2'd3, 2'd0, 2'd1, 2'd2}
  };

  localparam logic TERM_NEG [4][4] = '{
    '{1'b0, 1'b0, 1'b0, 1'b1},
    '{1'b0, 1'b1, 1'b0, 1'b0},
    '{1'b0, 1'b0, 1'b1, 1'b0},
    '{1'b0, 1'b1, 1'b1, 1'b1}
  };

  localparam idx_t IDX_W = 2'd3;

endpackage

>>> sv/qmr_hamilton.sv
`timescale 1ns / 1ps

module qmr_hamilton #(
  parameter int unsigned DATA_WIDTH = qmr_pkg::DATA_WIDTH_DEF,
  parameter int unsigned FRAC_BITS  = qmr_pkg::FRAC_BITS_DEF,
  parameter int unsigned AUX_W      = 1
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  input  qmr_pkg::qmr_ctl_t            ctl_i,
  input  logic                         conj_i,
  input  logic signed [DATA_WIDTH-1:0] p_i [4],
  input  logic signed [DATA_WIDTH-1:0] q_i [4],
  input  logic [AUX_W-1:0]             aux_i,
  output logic                         valid_o,
  output qmr_pkg::qmr_ctl_t            ctl_o,
  output logic signed [DATA_WIDTH-1:0] r_o [4],
  output logic [3:0]                   clip_o,
  output logic [AUX_W-1:0]             aux_o
);

  import qmr_pkg::*;

  localparam int unsigned PROD_W = 2 * DATA_WIDTH;
  localparam int unsigned SUM_W  = PROD_W + 2;
  localparam int unsigned EXT_W  = SUM_W + DATA_WIDTH;
  localparam logic [DATA_WIDTH-1:0] MAX_POS = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic [DATA_WIDTH-1:0] MIN_NEG = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  // stage 1: products
  logic                     s1_valid_q;
  qmr_ctl_t                 s1_ctl_q;
  logic [AUX_W-1:0]         s1_aux_q;
  logic signed [PROD_W-1:0] prod_d [4][4];
  logic signed [PROD_W-1:0] prod_q [4][4];
  logic [3:0]               neg_d  [4];
  logic [3:0]               neg_q  [4];

  // stage 2: exact sums
  logic                     s2_valid_q;
  qmr_ctl_t                 s2_ctl_q;
  logic [AUX_W-1:0]         s2_aux_q;
  logic signed [SUM_W-1:0]  sum_d [4];
  logic signed [SUM_W-1:0]  sum_q [4];

  // stage 3: shift and saturate
  logic                         s3_valid_q;
  qmr_ctl_t                     s3_ctl_q;
  logic [AUX_W-1:0]             s3_aux_q;
  logic signed [EXT_W-1:0]      shf   [4];
  logic [EXT_W-DATA_WIDTH:0]    upper [4];
  logic signed [DATA_WIDTH-1:0] r_d   [4];
  logic signed [DATA_WIDTH-1:0] r_q   [4];
  logic [3:0]                   clip_d;
  logic [3:0]                   clip_q;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      for (int t = 0; t < 4; t++) begin
        prod_d[k][t] = p_i[P_IDX[k][t]] * q_i[Q_IDX[k][t]];
        // conjugate of q flips every term that uses a vector part of q
        neg_d[k][t]  = TERM_NEG[k][t] ^ (conj_i && (Q_IDX[k][t] != IDX_W));
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      sum_d[k] = '0;
      for (int t = 0; t < 4; t++) begin
        if (neg_q[k][t]) begin
          sum_d[k] = sum_d[k] - SUM_W'(prod_q[k][t]);
        end else begin
          sum_d[k] = sum_d[k] + SUM_W'(prod_q[k][t]);
        end
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      shf[k]   = EXT_W'(sum_q[k]) >>> FRAC_BITS;
      upper[k] = shf[k][EXT_W-1:DATA_WIDTH-1];
      if ((&upper[k]) || !(|upper[k])) begin
        r_d[k]    = shf[k][DATA_WIDTH-1:0];
        clip_d[k] = 1'b0;
      end else begin
        r_d[k]    = sum_q[k][SUM_W-1] ? MIN_NEG : MAX_POS;
        clip_d[k] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= valid_i;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_ctl_q <= ctl_i;
    s1_aux_q <= aux_i;
    prod_q   <= prod_d;
    neg_q    <= neg_d;
    s2_ctl_q <= s1_ctl_q;
    s2_aux_q <= s1_aux_q;
    sum_q    <= sum_d;
    s3_ctl_q <= s2_ctl_q;
    s3_aux_q <= s2_aux_q;
    r_q      <= r_d;
    clip_q   <= clip_d;
  end

  assign valid_o = s3_valid_q;
  assign ctl_o   = s3_ctl_q;
  assign r_o     = r_q;
  assign clip_o  = clip_q;
  assign aux_o   = s3_aux_q;

endmodule

>>> sv/quaternion_multiply_rotate_core.sv
`timescale 1ns / 1ps

// Fixed-point quaternion unit: Hamilton product A*B (kind 0) or rotation of
// (b_x, b_y, b_z) as A*v*conj(A) (kind 1, r_w = 0). A new transaction is taken
// in every cycle; busy_o never rises. Each result leaves on result_valid_o
// exactly 7 cycles after its start_i, in order, for one cycle only: the
// receiver cannot stall and must take it then. The latency is two
// three-stage Hamilton passes (multiply, exact sum, shift and saturate),
// both used for every transaction, plus the result register.
module quaternion_multiply_rotate_core #(
  parameter int unsigned DATA_WIDTH = qmr_pkg::DATA_WIDTH_DEF,
  parameter int unsigned FRAC_BITS  = qmr_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic                         kind_i,
  input  logic signed [DATA_WIDTH-1:0] a_x_i,
  input  logic signed [DATA_WIDTH-1:0] a_y_i,
  input  logic signed [DATA_WIDTH-1:0] a_z_i,
  input  logic signed [DATA_WIDTH-1:0] a_w_i,
  input  logic signed [DATA_WIDTH-1:0] b_x_i,
  input  logic signed [DATA_WIDTH-1:0] b_y_i,
  input  logic signed [DATA_WIDTH-1:0] b_z_i,
  input  logic signed [DATA_WIDTH-1:0] b_w_i,
  output logic                         result_valid_o,
  output logic signed [DATA_WIDTH-1:0] r_x_o,
  output logic signed [DATA_WIDTH-1:0] r_y_o,
  output logic signed [DATA_WIDTH-1:0] r_z_o,
  output logic signed [DATA_WIDTH-1:0] r_w_o,
  output logic                         saturated_o
);

  import qmr_pkg::*;

  localparam int unsigned AUX_W = 4 * DATA_WIDTH;

  logic                         in_valid;
  qmr_ctl_t                     ctl1_in;
  logic signed [DATA_WIDTH-1:0] a_vec [4];
  logic signed [DATA_WIDTH-1:0] b_vec [4];
  logic [AUX_W-1:0]             a_pack;

  logic                         p1_valid;
  qmr_ctl_t                     p1_ctl;
  logic signed [DATA_WIDTH-1:0] t_vec [4];
  logic [3:0]                   p1_clip;
  logic [AUX_W-1:0]             p1_aux;
  logic signed [DATA_WIDTH-1:0] a_dly [4];
  qmr_ctl_t                     ctl2_in;
  logic [AUX_W-1:0]             t_pack;

  logic                         p2_valid;
  qmr_ctl_t                     p2_ctl;
  logic signed [DATA_WIDTH-1:0] rot_vec [4];
  logic [3:0]                   p2_clip;
  logic [AUX_W-1:0]             p2_aux;

  logic                         out_valid_q;
  logic signed [DATA_WIDTH-1:0] r_x_d, r_y_d, r_z_d, r_w_d;
  logic signed [DATA_WIDTH-1:0] r_x_q, r_y_q, r_z_q, r_w_q;
  logic                         sat_d, sat_q;

  assign busy_o   = 1'b0;
  assign in_valid = start_i && !busy_o;

  assign a_vec = '{a_x_i, a_y_i, a_z_i, a_w_i};
  // rotation uses v = (b_x, b_y, b_z, 0)
  assign b_vec = '{b_x_i, b_y_i, b_z_i, kind_i ? '0 : b_w_i};
  assign a_pack = {a_w_i, a_z_i, a_y_i, a_x_i};
  assign ctl1_in = '{kind: kind_i, sat: 1'b0};

  qmr_hamilton #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS),
    .AUX_W      (AUX_W)
  ) u_pass1 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid),
    .ctl_i   (ctl1_in),
    .conj_i  (1'b0),
    .p_i     (a_vec),
    .q_i     (b_vec),
    .aux_i   (a_pack),
    .valid_o (p1_valid),
    .ctl_o   (p1_ctl),
    .r_o     (t_vec),
    .clip_o  (p1_clip),
    .aux_o   (p1_aux)
  );

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      a_dly[i] = p1_aux[i*DATA_WIDTH +: DATA_WIDTH];
    end
  end

  assign t_pack  = {t_vec[3], t_vec[2], t_vec[1], t_vec[0]};
  assign ctl2_in = '{kind: p1_ctl.kind, sat: |p1_clip};

  // second pass: T * conj(A); for a product it only carries T along
  qmr_hamilton #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS),
    .AUX_W      (AUX_W)
  ) u_pass2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (p1_valid),
    .ctl_i   (ctl2_in),
    .conj_i  (1'b1),
    .p_i     (t_vec),
    .q_i     (a_dly),
    .aux_i   (t_pack),
    .valid_o (p2_valid),
    .ctl_o   (p2_ctl),
    .r_o     (rot_vec),
    .clip_o  (p2_clip),
    .aux_o   (p2_aux)
  );

  always_comb begin
    if (p2_ctl.kind) begin
      r_x_d = rot_vec[0];
      r_y_d = rot_vec[1];
      r_z_d = rot_vec[2];
      r_w_d = '0;
      // scalar of the rotated result is dropped, so its clip is too
      sat_d = p2_ctl.sat || (|p2_clip[2:0]);
    end else begin
      r_x_d = p2_aux[0*DATA_WIDTH +: DATA_WIDTH];
      r_y_d = p2_aux[1*DATA_WIDTH +: DATA_WIDTH];
      r_z_d = p2_aux[2*DATA_WIDTH +: DATA_WIDTH];
      r_w_d = p2_aux[3*DATA_WIDTH +: DATA_WIDTH];
      sat_d = p2_ctl.sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= p2_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    r_x_q <= r_x_d;
    r_y_q <= r_y_d;
    r_z_q <= r_z_d;
    r_w_q <= r_w_d;
    sat_q <= sat_d;
  end

  assign result_valid_o = out_valid_q;
  assign r_x_o          = r_x_q;
  assign r_y_o          = r_y_q;
  assign r_z_o          = r_z_q;
  assign r_w_o          = r_w_q;
  assign saturated_o    = sat_q;

  a_start_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid |-> ##LATENCY result_valid_o)
    else $error("accepted transaction produced no result");

  a_no_phantom : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid |-> ##LATENCY !result_valid_o)
    else $error("result without accepted transaction");

  a_rot_w_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && $past(kind_i, LATENCY)) |-> (r_w_o == '0))
    else $error("rotation result has nonzero scalar");

  a_pass_align : assert property (@(posedge clk_i) disable iff (!rst_ni)
    p1_valid |-> ##PASS_LAT p2_valid)
    else $error("second pass lost a transaction");

endmodule
